@@ rtl/afq_pkg.sv @@
// Package for the aging FIFO timeout queue.
// Shared constants and the pointer-unit command/status types. No dependencies.
package afq_pkg;

    localparam int AFQ_DEPTH    = 1024;
    localparam int HANDLE_W     = 32;
    localparam int STAMP_W      = 32;
    localparam int ENTRY_W      = HANDLE_W + STAMP_W;
    localparam int PEND_W       = 11;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 48;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_POP = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } ptr_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ptr_flags_t;

endpackage

@@ rtl/afq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module afq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/afq_ptrs.sv @@
// Head/tail pointers and occupancy count of the queue.
// Depends on afq_pkg.
module afq_ptrs import afq_pkg::*; #(
    parameter int DEPTH = AFQ_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ptr_cmd_t                   cmd,
    output logic [$clog2(DEPTH)-1:0]   head,
    output logic [$clog2(DEPTH)-1:0]   tail,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output ptr_flags_t                 flags
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head        = head_reg;
    assign tail        = tail_reg;
    assign count       = count_reg;
    assign flags.full  = (count_reg == FULL_CNT);
    assign flags.empty = (count_reg == '0);

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= FULL_CNT)
        else $error("occupancy above depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push && flags.full) && !(cmd.pop && flags.empty))
        else $error("pointer command against full or empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        flags.empty |-> head_reg == tail_reg)
        else $error("empty queue with pointers apart");

endmodule

@@ rtl/aging_fifo_timeout_queue.sv @@
// Top level of the aging FIFO timeout queue: request FSM and result register.
// Depends on afq_pkg, afq_ptrs, afq_ram.
//
// A FIFO of events, each stored with its arrival time stamp in one RAM.
// Input requests arrive on the s_ stream: s_tuser selects add (0) or pop (1),
// s_tdata carries the event handle and the current time. Every request gives
// exactly one result on the m_ stream: popped and dropped flags in m_tuser,
// the popped handle (zero otherwise) and the pending count in m_tdata.
// The timeout span is written over the cfg_ channel; the user must write it
// only while the block is idle; the block does not enforce this. An add, or a
// pop on an empty queue, shows its result in the cycle after it is accepted.
// A pop on a non-empty queue reads the oldest entry from the RAM, whose read
// is registered, and compares on the next cycle, in ST_CMP. Adds are taken at
// one request per cycle while the receiver takes each result; a non-empty pop
// holds off new requests in ST_CMP. Reset empties the queue and clears the
// span; RAM contents are not cleared since only written entries are ever
// read. If the receiver stalls, the result waits in the output register and
// one new request can be taken in the cycle the result is consumed.
module aging_fifo_timeout_queue import afq_pkg::*; #(
    parameter int DEPTH = AFQ_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // event_handle[31:0], now[63:32]
    input  logic [0:0]           s_tuser,   // kind[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // event_out[31:0], pending_count[42:32], zero
    output logic [1:0]           m_tuser,   // popped[0], dropped[1]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [STAMP_W-1:0]   cfg_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_CMP
    } state_t;

    state_t               state_reg, state_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 popped_reg, popped_next;
    logic                 dropped_reg, dropped_next;
    logic [HANDLE_W-1:0]  event_reg, event_next;
    logic [PEND_W-1:0]    pend_reg, pend_next;
    logic [STAMP_W-1:0]   now_reg, now_next;
    logic [STAMP_W-1:0]   span_reg;

    logic                 accept;
    logic                 is_pop;
    logic [HANDLE_W-1:0]  in_handle;
    logic [STAMP_W-1:0]   in_now;
    ptr_cmd_t             cmd;
    ptr_flags_t           flags;
    logic [PTR_W-1:0]     head;
    logic [PTR_W-1:0]     tail;
    logic [CNT_W-1:0]     count;
    logic [CNT_W-1:0]     res_count;
    logic [CNT_W+PEND_W-1:0] res_count_ext;
    logic                 rd_en;
    logic [ENTRY_W-1:0]   rd_data;
    logic [HANDLE_W-1:0]  rd_handle;
    logic [STAMP_W-1:0]   rd_stamp;
    logic                 timed_out;

    assign in_handle = s_tdata[HANDLE_W-1:0];
    assign in_now    = s_tdata[S_TDATA_W-1:HANDLE_W];
    assign is_pop    = (s_tuser[0] == KIND_POP);
    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign rd_handle = rd_data[HANDLE_W-1:0];
    assign rd_stamp  = rd_data[ENTRY_W-1:HANDLE_W];
    assign timed_out = (now_reg - rd_stamp) >= span_reg;

    assign cmd.push = accept && !is_pop && !flags.full;
    assign cmd.pop  = (state_reg == ST_CMP) && timed_out;
    assign rd_en    = accept && is_pop && !flags.empty;

    always_comb begin
        if (cmd.push) begin
            res_count = count + CNT_W'(1);
        end else if (cmd.pop) begin
            res_count = count - CNT_W'(1);
        end else begin
            res_count = count;
        end
    end
    assign res_count_ext = {{PEND_W{1'b0}}, res_count};

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        popped_next   = popped_reg;
        dropped_next  = dropped_reg;
        event_next    = event_reg;
        pend_next     = pend_reg;
        now_next      = now_reg;
        case (state_reg)
            ST_IDLE: begin
                if (rd_en) begin
                    now_next   = in_now;
                    state_next = ST_CMP;
                end else if (accept) begin
                    m_tvalid_next = 1'b1;
                    popped_next   = 1'b0;
                    event_next    = '0;
                    dropped_next  = !is_pop && flags.full;
                    pend_next     = res_count_ext[PEND_W-1:0];
                end
            end
            ST_CMP: begin
                m_tvalid_next = 1'b1;
                popped_next   = timed_out;
                event_next    = timed_out ? rd_handle : '0;
                dropped_next  = 1'b0;
                pend_next     = res_count_ext[PEND_W-1:0];
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            span_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                span_reg <= cfg_data;
            end
        end
        popped_reg  <= popped_next;
        dropped_reg <= dropped_next;
        event_reg   <= event_next;
        pend_reg    <= pend_next;
        now_reg     <= now_next;
    end

    afq_ptrs #(
        .DEPTH (DEPTH)
    ) u_ptrs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .head    (head),
        .tail    (tail),
        .count   (count),
        .flags   (flags)
    );

    afq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (cmd.push),
        .waddr (tail),
        .wdata ({in_now, in_handle}),
        .re    (rd_en),
        .raddr (head),
        .rdata (rd_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {dropped_reg, popped_reg};
    assign m_tdata  = {{(M_TDATA_W - HANDLE_W - PEND_W){1'b0}}, pend_reg, event_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both popped and dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[HANDLE_W-1:0] == '0))
        else $error("handle shown without a pop");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("compare did not produce a result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> (state_reg == ST_CMP) && !m_tvalid)
        else $error("pop read did not enter compare");

endmodule
